[rtl/tsfp_pkg.sv]
// Shared types, constants and helpers for the tagged serial frame parser.
// Used by every module under rtl/. No dependencies.
package tsfp_pkg;

  localparam int MAC_BYTES_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Tags as seen in the 4-byte window, oldest byte in the top bits.
  localparam logic [31:0] TAG_PKT = 32'h504B_543E;  // "PKT>"
  localparam logic [31:0] TAG_MAC = 32'h4D41_433E;  // "MAC>"
  localparam logic [31:0] TAG_VER = 32'h5645_523E;  // "VER>"
  localparam logic [31:0] TAG_TXC = 32'h5458_433E;  // "TXC>"
  localparam logic [31:0] TAG_TXF = 32'h5458_4621;  // "TXF!"
  localparam logic [31:0] TAG_CRC = 32'h4352_4321;  // "CRC!"
  localparam logic [31:0] TAG_RDY = 32'h5244_593E;  // "RDY>"

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_MAC     = 2'd1,
    KIND_VERSION = 2'd2,
    KIND_STATUS  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_COMPLETE  = 2'd0,
    ST_CRC_ERROR = 2'd1,
    ST_TX_ERROR  = 2'd2,
    ST_READY     = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_LENGTH  = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_MAC     = 5'b01000,
    PH_VERSION = 5'b10000
  } phase_t;

  // One classified received byte, as carried through the queue.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_hex;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] digit;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.digit  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.digit = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.digit = c[3:0] + 4'd9;
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

[rtl/tsfp_front.sv]
// Front end: takes received bytes and classifies them as hex digits.
// Depends on tsfp_pkg.
module tsfp_front (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,
  input  logic               q_ready,
  output logic               push,
  output tsfp_pkg::item_t    item
);

  tsfp_pkg::hex_t hex;

  assign hex          = tsfp_pkg::hex_decode(s_tdata);
  assign s_tready     = q_ready;
  assign push         = s_tvalid & q_ready;
  assign item.rx_byte = s_tdata;
  assign item.is_hex  = hex.is_hex;
  assign item.digit   = hex.digit;

endmodule

[rtl/tsfp_queue.sv]
// Short FIFO of classified bytes between front and back end.
// Depends on tsfp_pkg.
module tsfp_queue #(
  parameter int DEPTH = tsfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tsfp_pkg::item_t push_item,
  output logic            ready,
  output logic            valid,
  input  logic            pop,
  output tsfp_pkg::item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  tsfp_pkg::item_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign ready    = (count != CNT_FULL);
  assign valid    = (count != '0);
  assign do_push  = push & ready;
  assign do_pop   = pop & valid;
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/tsfp_back.sv]
// Back end: tag search and field parsing, one queued byte per cycle while
// the output is not stalled, with the output register. Depends on tsfp_pkg.
module tsfp_back #(
  parameter int MAC_BYTES = tsfp_pkg::MAC_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  tsfp_pkg::item_t q_item,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [31:0]     m_tdata,
  output logic            m_tlast
);

  localparam logic [8:0] MAC_COUNT = 9'(MAC_BYTES);

  tsfp_pkg::phase_t phase, phase_next;
  logic [31:0] win, win_next;
  logic [7:0]  len, len_next;
  logic [7:0]  pos, pos_next;
  logic [1:0]  cnt, cnt_next;
  logic [15:0] acc, acc_next;
  logic        ended, ended_next;
  logic        ver_pending, ver_pending_next;

  logic        emit;
  logic [1:0]  res_kind;
  logic [15:0] res_value;
  logic [7:0]  res_pos;
  logic        res_last;

  logic [31:0] shifted;
  logic [15:0] acc_h;
  logic        ended_h;
  logic [1:0]  cnt_inc;
  logic [7:0]  pos_inc;

  logic [1:0]  kind_q;
  logic [15:0] value_q;
  logic [7:0]  position_q;

  assign pop     = q_valid & (~m_tvalid | m_tready);
  assign shifted = {win[23:0], q_item.rx_byte};
  assign cnt_inc = cnt + 2'd1;
  assign pos_inc = pos + 8'd1;

  // digit accumulation; a non-hex char freezes the number
  always_comb begin
    acc_h   = acc;
    ended_h = ended;
    if (q_item.is_hex) begin
      if (!ended) begin
        acc_h = {acc[11:0], q_item.digit};
      end
    end else begin
      ended_h = 1'b1;
    end
  end

  always_comb begin
    phase_next       = phase;
    win_next         = win;
    len_next         = len;
    pos_next         = pos;
    cnt_next         = cnt;
    acc_next         = acc;
    ended_next       = ended;
    ver_pending_next = ver_pending;
    emit             = 1'b0;
    res_kind         = tsfp_pkg::KIND_PAYLOAD;
    res_value        = '0;
    res_pos          = '0;
    res_last         = 1'b0;
    if (pop) begin
      unique case (phase)
        tsfp_pkg::PH_LENGTH: begin
          len_next   = q_item.rx_byte;
          pos_next   = '0;
          phase_next = (q_item.rx_byte == 8'd0) ? tsfp_pkg::PH_HEADER
                                                 : tsfp_pkg::PH_PAYLOAD;
        end
        tsfp_pkg::PH_PAYLOAD: begin
          emit      = 1'b1;
          res_kind  = tsfp_pkg::KIND_PAYLOAD;
          res_value = {8'd0, q_item.rx_byte};
          res_pos   = pos;
          res_last  = (pos_inc == len);
          pos_next  = pos_inc;
          if (res_last) begin
            phase_next = tsfp_pkg::PH_HEADER;
          end
        end
        tsfp_pkg::PH_MAC: begin
          if (cnt_inc == 2'd2) begin
            emit       = 1'b1;
            res_kind   = tsfp_pkg::KIND_MAC;
            res_value  = {8'd0, acc_h[7:0]};
            res_pos    = pos;
            res_last   = ({1'b0, pos} + 9'd1 == MAC_COUNT);
            pos_next   = pos_inc;
            cnt_next   = '0;
            acc_next   = '0;
            ended_next = 1'b0;
            if (res_last) begin
              phase_next = tsfp_pkg::PH_HEADER;
            end
          end else begin
            cnt_next   = cnt_inc;
            acc_next   = acc_h;
            ended_next = ended_h;
          end
        end
        tsfp_pkg::PH_VERSION: begin
          if (cnt == 2'd3) begin
            emit       = 1'b1;
            res_kind   = tsfp_pkg::KIND_VERSION;
            res_value  = acc_h;
            cnt_next   = '0;
            acc_next   = '0;
            ended_next = 1'b0;
            phase_next = tsfp_pkg::PH_HEADER;
          end else begin
            cnt_next   = cnt_inc;
            acc_next   = acc_h;
            ended_next = ended_h;
          end
        end
        default: begin
          // header search; stray phase codes land here too
          phase_next = tsfp_pkg::PH_HEADER;
          win_next   = shifted;
          res_kind   = tsfp_pkg::KIND_STATUS;
          if (shifted == tsfp_pkg::TAG_PKT) begin
            phase_next = tsfp_pkg::PH_LENGTH;
            cnt_next   = '0;
            acc_next   = '0;
            ended_next = 1'b0;
            win_next   = '0;
          end else if (shifted == tsfp_pkg::TAG_MAC) begin
            phase_next = tsfp_pkg::PH_MAC;
            pos_next   = '0;
            cnt_next   = '0;
            acc_next   = '0;
            ended_next = 1'b0;
            win_next   = '0;
          end else if (shifted == tsfp_pkg::TAG_VER) begin
            if (ver_pending) begin
              ver_pending_next = 1'b0;
              phase_next       = tsfp_pkg::PH_VERSION;
              pos_next         = '0;
              cnt_next         = '0;
              acc_next         = '0;
              ended_next       = 1'b0;
              win_next         = '0;
            end
          end else if (shifted == tsfp_pkg::TAG_TXC) begin
            emit      = 1'b1;
            res_value = {14'd0, tsfp_pkg::ST_COMPLETE};
          end else if (shifted == tsfp_pkg::TAG_CRC) begin
            emit      = 1'b1;
            res_value = {14'd0, tsfp_pkg::ST_CRC_ERROR};
          end else if (shifted == tsfp_pkg::TAG_TXF) begin
            emit      = 1'b1;
            res_value = {14'd0, tsfp_pkg::ST_TX_ERROR};
          end else if (shifted == tsfp_pkg::TAG_RDY) begin
            emit      = 1'b1;
            res_value = {14'd0, tsfp_pkg::ST_READY};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= tsfp_pkg::PH_HEADER;
      win         <= '0;
      len         <= '0;
      pos         <= '0;
      cnt         <= '0;
      acc         <= '0;
      ended       <= 1'b0;
      ver_pending <= 1'b1;
      m_tvalid    <= 1'b0;
    end else begin
      phase       <= phase_next;
      win         <= win_next;
      len         <= len_next;
      pos         <= pos_next;
      cnt         <= cnt_next;
      acc         <= acc_next;
      ended       <= ended_next;
      ver_pending <= ver_pending_next;
      if (pop) begin
        m_tvalid <= emit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload; loaded only when a result is produced
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind_q     <= res_kind;
      value_q    <= res_value;
      position_q <= res_pos;
      m_tlast    <= res_last;
    end
  end

  assign m_tdata = {6'd0, position_q, value_q, kind_q};

endmodule

[rtl/tagged_serial_frame_parser.sv]
// Top level of the tagged serial frame parser.
// Depends on tsfp_pkg, tsfp_front, tsfp_queue and tsfp_back.
//
// Usage:
//   Slave channel (s_*): one received serial byte per transfer in s_tdata.
//   Master channel (m_*): at most one result per byte. m_tdata carries
//   result_kind, value and position; m_tlast marks the final payload byte
//   or the final MAC byte.
//   The parser hunts for PKT>, MAC>, VER> (taken once after reset), TXC>,
//   TXF!, CRC! and RDY> in a sliding 4-byte window. PKT> is followed by a
//   length byte and that many payload bytes (zero length returns straight
//   to the hunt). MAC> is followed by 2*MAC_BYTES hex chars, VER> by four.
// Timing:
//   One byte per cycle sustained while results are taken. An accepted byte
//   is written into the FIFO, parsed when the parser pops it, and its
//   result is loaded into the result register that drives m_*.
//   The parser state update closes a loop on the parser registers.
//   A QUEUE_DEPTH-entry FIFO sits between the byte classifier and the
//   parser; s_tready drops only when it is full. When the receiver stalls
//   the result register holds, the parser stops, and the FIFO absorbs input.
// Reset:
//   rst (synchronous, active high) empties the FIFO, drops m_tvalid, clears
//   the window and returns to the header hunt with VER> armed again.
module tagged_serial_frame_parser #(
  parameter int MAC_BYTES   = tsfp_pkg::MAC_BYTES_DEF,
  parameter int QUEUE_DEPTH = tsfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [1:0] result_kind, [17:2] value, [25:18] position
  output logic        m_tlast
);

  tsfp_pkg::item_t push_item;
  tsfp_pkg::item_t pop_item;
  logic            push;
  logic            q_ready;
  logic            q_valid;
  logic            pop;

  // byte classification
  tsfp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_ready  (q_ready),
    .push     (push),
    .item     (push_item)
  );

  // decoupling FIFO
  tsfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .ready     (q_ready),
    .valid     (q_valid),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  // tag hunt, field parsing, result register
  tsfp_back #(
    .MAC_BYTES (MAC_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (pop_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // an accepted byte is in the FIFO on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> q_valid)
    else $error("accepted byte missing from queue");

  // last only marks payload or MAC bytes
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |->
      (m_tdata[1:0] == tsfp_pkg::KIND_PAYLOAD || m_tdata[1:0] == tsfp_pkg::KIND_MAC))
    else $error("last set on version or status result");

  // version and status results carry position zero
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] == tsfp_pkg::KIND_VERSION ||
                  m_tdata[1:0] == tsfp_pkg::KIND_STATUS)) |-> (m_tdata[25:18] == 8'd0))
    else $error("nonzero position on version or status result");

  // parser never pops while a result is stalled
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !pop)
    else $error("parser advanced under output stall");

endmodule
